/* design/cpq_pkg.sv */
// Shared constants, codes and types for the capsule point query block.
// No dependencies; imported by the top level and the checker.
package cpq_pkg;

   localparam int CPQ_COORD_WIDTH = 32;  // default coordinate width
   localparam int CPQ_FRAC_W      = 64;  // bits of the projection fraction
   localparam int CPQ_HALF_W      = 32;  // fraction half used per multiply
   localparam int CPQ_IDX_W       = 3;   // csr index width

   typedef enum logic [CPQ_IDX_W-1:0] {
      REG_START_X    = 3'd0,
      REG_START_Y    = 3'd1,
      REG_END_X      = 3'd2,
      REG_END_Y      = 3'd3,
      REG_CAP_RADIUS = 3'd4
   } csr_index_type;

   // where the projection lands on the segment
   typedef enum logic [1:0] {
      CLAMP_START,
      CLAMP_END,
      CLAMP_MID
   } clamp_type;

   // clock edges from the input transfer edge to the edge sampling the strobe
   function automatic int cpq_latency(input int cw);
      return 2 * cw + 80;
   endfunction

endpackage

/* design/cpq_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Standalone; used for the projection fraction and the surface offsets.
module cpq_div #(
   parameter int REM_W = 33,
   parameter int QUO_W = 31,
   parameter int SB_W  = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [REM_W-1:0] in_rem,
   input  logic [REM_W-1:0] in_den,
   input  logic [QUO_W-1:0] in_low,
   input  logic [SB_W-1:0]  in_sb,
   output logic             out_valid,
   output logic [QUO_W-1:0] out_quo,
   output logic [SB_W-1:0]  out_sb
);

   logic             valid_ff [1:QUO_W];
   logic [REM_W-1:0] rem_ff   [1:QUO_W];
   logic [REM_W-1:0] den_ff   [1:QUO_W];
   logic [QUO_W-1:0] quo_ff   [1:QUO_W];  // low dividend bits shift out, quotient in
   logic [SB_W-1:0]  sb_ff    [1:QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      logic             v_cur;
      logic [REM_W-1:0] rem_cur;
      logic [REM_W-1:0] den_cur;
      logic [QUO_W-1:0] quo_cur;
      logic [SB_W-1:0]  sb_cur;
      logic [REM_W:0]   trial;
      logic             ge;
      logic [REM_W-1:0] rem_in;

      if (k == 0) begin : g_in
         assign v_cur   = in_valid;
         assign rem_cur = in_rem;
         assign den_cur = in_den;
         assign quo_cur = in_low;
         assign sb_cur  = in_sb;
      end else begin : g_mid
         assign v_cur   = valid_ff[k];
         assign rem_cur = rem_ff[k];
         assign den_cur = den_ff[k];
         assign quo_cur = quo_ff[k];
         assign sb_cur  = sb_ff[k];
      end

      always_comb begin
         trial  = {rem_cur, quo_cur[QUO_W-1]};
         ge     = trial >= {1'b0, den_cur};
         rem_in = ge ? REM_W'(trial - {1'b0, den_cur}) : trial[REM_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= v_cur;
         end
         rem_ff[k+1] <= rem_in;
         den_ff[k+1] <= den_cur;
         quo_ff[k+1] <= {quo_cur[QUO_W-2:0], ge};
         sb_ff[k+1]  <= sb_cur;
      end
   end

   assign out_valid = valid_ff[QUO_W];
   assign out_quo   = quo_ff[QUO_W];
   assign out_sb    = sb_ff[QUO_W];

endmodule

/* design/cpq_isqrt.sv */
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Standalone; used for the distance from the segment.
module cpq_isqrt #(
   parameter int ROOT_W = 33,
   parameter int SB_W   = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [2*ROOT_W-1:0] in_rad,
   input  logic [SB_W-1:0]     in_sb,
   output logic                out_valid,
   output logic [ROOT_W-1:0]   out_root,
   output logic [SB_W-1:0]     out_sb
);

   localparam int RAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 1;
   localparam int CUR_W = ROOT_W + 3;

   logic              valid_ff [1:ROOT_W];
   logic [REM_W-1:0]  rem_ff   [1:ROOT_W];
   logic [ROOT_W-1:0] root_ff  [1:ROOT_W];
   logic [RAD_W-1:0]  rad_ff   [1:ROOT_W];
   logic [SB_W-1:0]   sb_ff    [1:ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_step
      logic              v_cur;
      logic [REM_W-1:0]  rem_cur;
      logic [ROOT_W-1:0] root_cur;
      logic [RAD_W-1:0]  rad_cur;
      logic [SB_W-1:0]   sb_cur;
      logic [CUR_W-1:0]  cur;
      logic [CUR_W-1:0]  trial;
      logic              ge;
      logic [REM_W-1:0]  rem_in;

      if (k == 0) begin : g_in
         assign v_cur    = in_valid;
         assign rem_cur  = '0;
         assign root_cur = '0;
         assign rad_cur  = in_rad;
         assign sb_cur   = in_sb;
      end else begin : g_mid
         assign v_cur    = valid_ff[k];
         assign rem_cur  = rem_ff[k];
         assign root_cur = root_ff[k];
         assign rad_cur  = rad_ff[k];
         assign sb_cur   = sb_ff[k];
      end

      always_comb begin
         cur    = {rem_cur, rad_cur[RAD_W-1 -: 2]};
         trial  = CUR_W'({root_cur, 2'b01});
         ge     = cur >= trial;
         rem_in = ge ? REM_W'(cur - trial) : cur[REM_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= v_cur;
         end
         rem_ff[k+1]  <= rem_in;
         root_ff[k+1] <= {root_cur[ROOT_W-2:0], ge};
         rad_ff[k+1]  <= {rad_cur[RAD_W-3:0], 2'b00};
         sb_ff[k+1]   <= sb_cur;
      end
   end

   assign out_valid = valid_ff[ROOT_W];
   assign out_root  = root_ff[ROOT_W];
   assign out_sb    = sb_ff[ROOT_W];

endmodule

/* design/capsule_point_query_2d.sv */
// Top level of the 2D point-to-capsule query: registers, datapath stages.
// Depends on cpq_pkg, cpq_div and cpq_isqrt.
//
// Usage
//   Configuration: csr_we/csr_index/csr_wdata write start_x, start_y, end_x,
//   end_y and cap_radius (indexes 0..4); other indexes are dropped. Write
//   only while no query is in flight; derived terms settle before any item
//   that follows the write needs them.
//   Queries: a transfer happens at a rising edge with req_start high and
//   busy low. busy is high only in the cycle after a reset edge, so a new
//   point may enter every cycle.
//   Results: rsp_valid marks one cycle carrying rsp_inside_res, rsp_near_x
//   and rsp_near_y. The receiver cannot stall; results simply leave.
//   Depth: the pipe is built from the 64-stage fraction divider, the
//   COORD_WIDTH+1-stage square root and the COORD_WIDTH-1-stage offset
//   dividers, plus the multiply/add register stages around them.
//   Throughput: one point per clock while busy is low, results in input order.
//   Reset: synchronous; zeroes the configuration registers and empties the pipe.
module capsule_point_query_2d #(
   parameter int COORD_WIDTH = cpq_pkg::CPQ_COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   output logic                          rsp_valid,
   output logic                          rsp_inside_res,
   output logic signed [COORD_WIDTH-1:0] rsp_near_x,
   output logic signed [COORD_WIDTH-1:0] rsp_near_y,
   input  logic                          csr_we,
   input  logic [cpq_pkg::CPQ_IDX_W-1:0] csr_index,
   input  logic [COORD_WIDTH-1:0]        csr_wdata
);

   import cpq_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int VW = CW + 1;        // coordinate differences
   localparam int PW = 2 * CW + 2;    // products of differences
   localparam int TW = 2 * CW + 3;    // dot product
   localparam int LW = 2 * CW + 1;    // squared segment length
   localparam int FW = CPQ_FRAC_W;
   localparam int HW = CPQ_HALF_W;
   localparam int RW = CW - 1;        // radius
   localparam int DW = 2 * CW + 2;    // squared distance, root radicand
   localparam int SW = CW + 1;        // root
   localparam int NW = 2 * CW;        // offset numerator
   localparam int QW = CW - 1;        // offset quotient
   localparam int FSB_W = 2 + 2 * CW;
   localparam int SSB_W = 3 + 6 * CW;
   localparam int XSB_W = 2 + 3 * CW;
   localparam int YSB_W = 1 + CW;
   localparam logic [CW+FW-1:0] ROUND_HALF = (CW + FW)'(1) << (FW - 1);

   // ---------------- configuration registers ----------------
   logic signed [CW-1:0] start_x_ff, start_y_ff, end_x_ff, end_y_ff;
   logic [RW-1:0]        cap_radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff    <= '0;
         start_y_ff    <= '0;
         end_x_ff      <= '0;
         end_y_ff      <= '0;
         cap_radius_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_START_X:    start_x_ff    <= csr_wdata;
            REG_START_Y:    start_y_ff    <= csr_wdata;
            REG_END_X:      end_x_ff      <= csr_wdata;
            REG_END_Y:      end_y_ff      <= csr_wdata;
            REG_CAP_RADIUS: cap_radius_ff <= csr_wdata[RW-1:0];
            default: begin
            end
         endcase
      end
   end

   // Segment terms that depend on configuration only. After a write they
   // settle through the dx/dy, square and l2 registers before any stage reads them.
   logic signed [VW-1:0] dx_ff, dy_ff;
   logic [CW-1:0]        adx_ff, ady_ff;
   logic signed [PW-1:0] sqdx_ff, sqdy_ff;
   logic [LW-1:0]        l2_ff;
   logic                 zero_ff;
   logic [2*RW-1:0]      r2_ff;

   always_ff @(posedge clock) begin
      dx_ff   <= VW'(end_x_ff) - VW'(start_x_ff);
      dy_ff   <= VW'(end_y_ff) - VW'(start_y_ff);
      adx_ff  <= dx_ff[VW-1] ? CW'(-dx_ff) : CW'(dx_ff);
      ady_ff  <= dy_ff[VW-1] ? CW'(-dy_ff) : CW'(dy_ff);
      sqdx_ff <= dx_ff * dx_ff;
      sqdy_ff <= dy_ff * dy_ff;
      l2_ff   <= LW'(sqdx_ff + sqdy_ff);
      zero_ff <= (dx_ff == '0) && (dy_ff == '0);
      r2_ff   <= cap_radius_ff * cap_radius_ff;
   end

   // ---------------- input stage ----------------
   logic busy_ff;
   logic accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = req_start && !busy_ff;

   logic                 v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [CW-1:0] px0_ff, py0_ff, px1_ff, py1_ff, px2_ff, py2_ff;
   logic signed [CW-1:0] px3_ff, py3_ff, px4_ff, py4_ff;
   logic signed [VW-1:0] vx1_ff, vy1_ff;
   logic signed [PW-1:0] pdx2_ff, pdy2_ff;
   logic signed [TW-1:0] t3_ff;
   clamp_type            mode4_ff, mode4_in;
   logic [LW-1:0]        num4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v0_ff <= accept;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      px0_ff  <= req_point_x;
      py0_ff  <= req_point_y;
      // offset of the point from the segment start
      px1_ff  <= px0_ff;
      py1_ff  <= py0_ff;
      vx1_ff  <= VW'(px0_ff) - VW'(start_x_ff);
      vy1_ff  <= VW'(py0_ff) - VW'(start_y_ff);
      // dot product terms
      px2_ff  <= px1_ff;
      py2_ff  <= py1_ff;
      pdx2_ff <= vx1_ff * dx_ff;
      pdy2_ff <= vy1_ff * dy_ff;
      px3_ff  <= px2_ff;
      py3_ff  <= py2_ff;
      t3_ff   <= TW'(pdx2_ff) + TW'(pdy2_ff);
      // clamp decision
      px4_ff   <= px3_ff;
      py4_ff   <= py3_ff;
      mode4_ff <= mode4_in;
      num4_ff  <= (mode4_in == CLAMP_MID) ? t3_ff[LW-1:0] : '0;
   end

   // degenerate segment or projection at or behind the start -> start point, at or past the end -> end point
   always_comb begin
      if (zero_ff || t3_ff[TW-1] || (t3_ff == '0)) begin
         mode4_in = CLAMP_START;
      end else if ($unsigned(t3_ff) >= TW'(l2_ff)) begin
         mode4_in = CLAMP_END;
      end else begin
         mode4_in = CLAMP_MID;
      end
   end

   // ---------------- projection fraction t / L2 ----------------
   logic             fd_valid;
   logic [FW-1:0]    fd_frac;
   logic [FSB_W-1:0] fd_sb;

   cpq_div #(
      .REM_W(LW),
      .QUO_W(FW),
      .SB_W (FSB_W)
   ) u_frac_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v4_ff),
      .in_rem   (num4_ff),
      .in_den   (l2_ff),
      .in_low   ('0),
      .in_sb    ({mode4_ff, px4_ff, py4_ff}),
      .out_valid(fd_valid),
      .out_quo  (fd_frac),
      .out_sb   (fd_sb)
   );

   clamp_type            fd_mode;
   logic signed [CW-1:0] fd_px, fd_py;

   assign fd_mode = clamp_type'(fd_sb[FSB_W-1 -: 2]);
   assign fd_px   = fd_sb[2*CW-1:CW];
   assign fd_py   = fd_sb[CW-1:0];

   // ---------------- closest segment point ----------------
   logic                 v5_ff, v6_ff, v7_ff, v8_ff, v9_ff, v10_ff, v11_ff;
   clamp_type            mode5_ff, mode6_ff;
   logic signed [CW-1:0] px5_ff, py5_ff, px6_ff, py6_ff, px7_ff, py7_ff;
   logic [CW+HW-1:0]     plx5_ff, ply5_ff, plx6_ff, ply6_ff, phx6_ff, phy6_ff;
   logic [HW-1:0]        fh5_ff;
   logic signed [CW-1:0] cx7_ff, cy7_ff, cx_in, cy_in;
   logic [CW+FW-1:0]     sumx, sumy;
   logic [CW-1:0]        offx, offy;
   logic [VW-1:0]        midx, midy;

   always_comb begin
      // |d| * f rounded half up, split over two multiplies
      sumx = {phx6_ff, HW'(0)} + (CW + FW)'(plx6_ff) + ROUND_HALF;
      sumy = {phy6_ff, HW'(0)} + (CW + FW)'(ply6_ff) + ROUND_HALF;
      offx = sumx[CW+FW-1:FW];
      offy = sumy[CW+FW-1:FW];
      midx = dx_ff[VW-1] ? VW'(start_x_ff) - {1'b0, offx} : VW'(start_x_ff) + {1'b0, offx};
      midy = dy_ff[VW-1] ? VW'(start_y_ff) - {1'b0, offy} : VW'(start_y_ff) + {1'b0, offy};
      case (mode6_ff)
         CLAMP_START: begin
            cx_in = start_x_ff;
            cy_in = start_y_ff;
         end
         CLAMP_END: begin
            cx_in = end_x_ff;
            cy_in = end_y_ff;
         end
         CLAMP_MID: begin
            cx_in = midx[CW-1:0];
            cy_in = midy[CW-1:0];
         end
         default: begin
            cx_in = start_x_ff;
            cy_in = start_y_ff;
         end
      endcase
   end

   // ---------------- offset from the segment, squared distance ----------------
   logic signed [CW-1:0] px8_ff, py8_ff, px9_ff, py9_ff, px10_ff, py10_ff, px11_ff, py11_ff;
   logic signed [CW-1:0] cx8_ff, cy8_ff, cx9_ff, cy9_ff, cx10_ff, cy10_ff, cx11_ff, cy11_ff;
   logic signed [VW-1:0] wx8_ff, wy8_ff;
   logic [CW-1:0]        awx9_ff, awy9_ff, awx10_ff, awy10_ff, awx11_ff, awy11_ff;
   logic                 swx9_ff, swy9_ff, swx10_ff, swy10_ff, swx11_ff, swy11_ff;
   logic [2*CW-1:0]      sqx10_ff, sqy10_ff;
   logic [DW-1:0]        dist2;
   logic [DW-1:0]        dist11_ff;
   logic                 inside11_ff;

   assign dist2 = DW'(sqx10_ff) + DW'(sqy10_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff  <= 1'b0;
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
         v11_ff <= 1'b0;
      end else begin
         v5_ff  <= fd_valid;
         v6_ff  <= v5_ff;
         v7_ff  <= v6_ff;
         v8_ff  <= v7_ff;
         v9_ff  <= v8_ff;
         v10_ff <= v9_ff;
         v11_ff <= v10_ff;
      end
      mode5_ff <= fd_mode;
      px5_ff   <= fd_px;
      py5_ff   <= fd_py;
      plx5_ff  <= adx_ff * fd_frac[HW-1:0];
      ply5_ff  <= ady_ff * fd_frac[HW-1:0];
      fh5_ff   <= fd_frac[FW-1:HW];

      mode6_ff <= mode5_ff;
      px6_ff   <= px5_ff;
      py6_ff   <= py5_ff;
      plx6_ff  <= plx5_ff;
      ply6_ff  <= ply5_ff;
      phx6_ff  <= adx_ff * fh5_ff;
      phy6_ff  <= ady_ff * fh5_ff;

      px7_ff <= px6_ff;
      py7_ff <= py6_ff;
      cx7_ff <= cx_in;
      cy7_ff <= cy_in;

      px8_ff <= px7_ff;
      py8_ff <= py7_ff;
      cx8_ff <= cx7_ff;
      cy8_ff <= cy7_ff;
      wx8_ff <= VW'(px7_ff) - VW'(cx7_ff);
      wy8_ff <= VW'(py7_ff) - VW'(cy7_ff);

      px9_ff  <= px8_ff;
      py9_ff  <= py8_ff;
      cx9_ff  <= cx8_ff;
      cy9_ff  <= cy8_ff;
      swx9_ff <= wx8_ff[VW-1];
      swy9_ff <= wy8_ff[VW-1];
      awx9_ff <= wx8_ff[VW-1] ? CW'(-wx8_ff) : CW'(wx8_ff);
      awy9_ff <= wy8_ff[VW-1] ? CW'(-wy8_ff) : CW'(wy8_ff);

      px10_ff  <= px9_ff;
      py10_ff  <= py9_ff;
      cx10_ff  <= cx9_ff;
      cy10_ff  <= cy9_ff;
      swx10_ff <= swx9_ff;
      swy10_ff <= swy9_ff;
      awx10_ff <= awx9_ff;
      awy10_ff <= awy9_ff;
      sqx10_ff <= awx9_ff * awx9_ff;
      sqy10_ff <= awy9_ff * awy9_ff;

      px11_ff     <= px10_ff;
      py11_ff     <= py10_ff;
      cx11_ff     <= cx10_ff;
      cy11_ff     <= cy10_ff;
      swx11_ff    <= swx10_ff;
      swy11_ff    <= swy10_ff;
      awx11_ff    <= awx10_ff;
      awy11_ff    <= awy10_ff;
      dist11_ff   <= dist2;
      inside11_ff <= DW'(r2_ff) >= dist2;
   end

   // ---------------- distance root ----------------
   logic             sq_valid;
   logic [SW-1:0]    sq_len;
   logic [SSB_W-1:0] sq_sb;

   cpq_isqrt #(
      .ROOT_W(SW),
      .SB_W  (SSB_W)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v11_ff),
      .in_rad   (dist11_ff),
      .in_sb    ({inside11_ff, px11_ff, py11_ff, cx11_ff, cy11_ff,
                  swx11_ff, swy11_ff, awx11_ff, awy11_ff}),
      .out_valid(sq_valid),
      .out_root (sq_len),
      .out_sb   (sq_sb)
   );

   logic                 sq_inside, sq_swx, sq_swy;
   logic signed [CW-1:0] sq_px, sq_py, sq_cx, sq_cy;
   logic [CW-1:0]        sq_awx, sq_awy;

   assign {sq_inside, sq_px, sq_py, sq_cx, sq_cy, sq_swx, sq_swy, sq_awx, sq_awy} = sq_sb;

   // ---------------- surface offset numerators ----------------
   logic                 v12_ff, v13_ff;
   logic                 inside12_ff, inside13_ff, swx12_ff, swy12_ff, swx13_ff, swy13_ff;
   logic signed [CW-1:0] px12_ff, py12_ff, cx12_ff, cy12_ff;
   logic signed [CW-1:0] px13_ff, py13_ff, cx13_ff, cy13_ff;
   logic [SW-1:0]        len12_ff, len13_ff;
   logic [NW-1:0]        prodx12_ff, prody12_ff, numx13_ff, numy13_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v12_ff <= 1'b0;
         v13_ff <= 1'b0;
      end else begin
         v12_ff <= sq_valid;
         v13_ff <= v12_ff;
      end
      inside12_ff <= sq_inside;
      px12_ff     <= sq_px;
      py12_ff     <= sq_py;
      cx12_ff     <= sq_cx;
      cy12_ff     <= sq_cy;
      swx12_ff    <= sq_swx;
      swy12_ff    <= sq_swy;
      // a zero root only shows up for inside points; keep the divider sane
      len12_ff    <= (sq_len == '0) ? SW'(1) : sq_len;
      prodx12_ff  <= NW'(sq_awx * cap_radius_ff);
      prody12_ff  <= NW'(sq_awy * cap_radius_ff);

      inside13_ff <= inside12_ff;
      px13_ff     <= px12_ff;
      py13_ff     <= py12_ff;
      cx13_ff     <= cx12_ff;
      cy13_ff     <= cy12_ff;
      swx13_ff    <= swx12_ff;
      swy13_ff    <= swy12_ff;
      len13_ff    <= len12_ff;
      numx13_ff   <= prodx12_ff + NW'(len12_ff >> 1);
      numy13_ff   <= prody12_ff + NW'(len12_ff >> 1);
   end

   // ---------------- surface offsets |w| * r / len ----------------
   logic             qx_valid, qy_valid;
   logic [QW-1:0]    qx, qy;
   logic [XSB_W-1:0] qx_sb;
   logic [YSB_W-1:0] qy_sb;

   cpq_div #(
      .REM_W(SW),
      .QUO_W(QW),
      .SB_W (XSB_W)
   ) u_surf_div_x (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v13_ff),
      .in_rem   (numx13_ff[NW-1:QW]),
      .in_den   (len13_ff),
      .in_low   (numx13_ff[QW-1:0]),
      .in_sb    ({inside13_ff, px13_ff, py13_ff, cx13_ff, swx13_ff}),
      .out_valid(qx_valid),
      .out_quo  (qx),
      .out_sb   (qx_sb)
   );

   cpq_div #(
      .REM_W(SW),
      .QUO_W(QW),
      .SB_W (YSB_W)
   ) u_surf_div_y (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v13_ff),
      .in_rem   (numy13_ff[NW-1:QW]),
      .in_den   (len13_ff),
      .in_low   (numy13_ff[QW-1:0]),
      .in_sb    ({cy13_ff, swy13_ff}),
      .out_valid(qy_valid),
      .out_quo  (qy),
      .out_sb   (qy_sb)
   );

   logic                 qd_inside, qd_swx, qd_swy;
   logic signed [CW-1:0] qd_px, qd_py, qd_cx, qd_cy;

   assign {qd_inside, qd_px, qd_py, qd_cx, qd_swx} = qx_sb;
   assign {qd_cy, qd_swy} = qy_sb;

   // ---------------- surface point, saturation, result register ----------------
   logic                 v14_ff, inside14_ff;
   logic signed [CW-1:0] px14_ff, py14_ff;
   logic signed [VW-1:0] nx14_ff, ny14_ff;
   logic                 rsp_valid_ff, rsp_inside_ff;
   logic signed [CW-1:0] rsp_near_x_ff, rsp_near_y_ff;
   logic signed [CW-1:0] satx, saty;
   logic signed [CW-1:0] sat_max, sat_min;

   assign sat_max = {1'b0, {(CW - 1){1'b1}}};
   assign sat_min = {1'b1, {(CW - 1){1'b0}}};

   always_comb begin
      if (nx14_ff[VW-1] != nx14_ff[VW-2]) begin
         satx = nx14_ff[VW-1] ? sat_min : sat_max;
      end else begin
         satx = nx14_ff[CW-1:0];
      end
      if (ny14_ff[VW-1] != ny14_ff[VW-2]) begin
         saty = ny14_ff[VW-1] ? sat_min : sat_max;
      end else begin
         saty = ny14_ff[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v14_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v14_ff       <= qx_valid && qy_valid;
         rsp_valid_ff <= v14_ff;
      end
      inside14_ff <= qd_inside;
      px14_ff     <= qd_px;
      py14_ff     <= qd_py;
      nx14_ff     <= qd_swx ? VW'(qd_cx) - VW'($signed({1'b0, qx}))
                            : VW'(qd_cx) + VW'($signed({1'b0, qx}));
      ny14_ff     <= qd_swy ? VW'(qd_cy) - VW'($signed({1'b0, qy}))
                            : VW'(qd_cy) + VW'($signed({1'b0, qy}));

      // inside points come back untouched
      rsp_inside_ff <= inside14_ff;
      rsp_near_x_ff <= inside14_ff ? px14_ff : satx;
      rsp_near_y_ff <= inside14_ff ? py14_ff : saty;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;
   assign rsp_near_x     = rsp_near_x_ff;
   assign rsp_near_y     = rsp_near_y_ff;

endmodule

/* design/cpq_checker.sv */
// Port-level checks on the capsule point query block, bound to its top.
// Depends on cpq_pkg and capsule_point_query_2d.
module cpq_checker #(
   parameter int COORD_WIDTH = cpq_pkg::CPQ_COORD_WIDTH
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_start,
   input logic                          busy,
   input logic signed [COORD_WIDTH-1:0] req_point_x,
   input logic signed [COORD_WIDTH-1:0] req_point_y,
   input logic                          rsp_valid,
   input logic                          rsp_inside_res,
   input logic signed [COORD_WIDTH-1:0] rsp_near_x,
   input logic signed [COORD_WIDTH-1:0] rsp_near_y,
   input logic                          csr_we,
   input logic [cpq_pkg::CPQ_IDX_W-1:0] csr_index,
   input logic [COORD_WIDTH-1:0]        csr_wdata
);

   import cpq_pkg::*;

   localparam int LAT = cpq_latency(COORD_WIDTH);

   logic xfer;

   assign xfer = req_start && !busy;

   // reset empties the pipe and blocks the input for a cycle
   a_reset_clears : assert property (@(posedge clock)
      reset |=> (!rsp_valid && busy))
      else $error("strobe or ready wrong after reset");

   a_result_follows : assert property (@(posedge clock) disable iff (reset)
      xfer |-> ##LAT rsp_valid)
      else $error("accepted point produced no result");

   a_no_stray : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(xfer, LAT))
      else $error("result without a matching transfer");

   a_inside_echo : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_inside_res) |->
         (rsp_near_x == $past(req_point_x, LAT)) && (rsp_near_y == $past(req_point_y, LAT)))
      else $error("inside point not returned unchanged");

   // configuration writes carry no handshake of their own
   logic unused_ok;
   assign unused_ok = csr_we ^ (^csr_index) ^ (^csr_wdata);

endmodule

bind capsule_point_query_2d cpq_checker #(.COORD_WIDTH(COORD_WIDTH)) u_cpq_checker (.*);
